[src/crrp_pkg.sv]
package crrp_pkg;

    // Default depth of the operation store
    localparam int MAX_OPS_DEF = 64;

    // Field widths fixed by the interface
    localparam int OP_W     = 4;
    localparam int LEN_W    = 28;
    localparam int ANCHOR_W = 31;
    localparam int OFF_W    = 32;
    localparam int POS_O_W  = 35;
    localparam int RULE_W   = 3;
    localparam int ENTRY_W  = OP_W + LEN_W;

    // CIGAR operation codes
    localparam logic [OP_W-1:0] OP_M  = 4'd0;
    localparam logic [OP_W-1:0] OP_I  = 4'd1;
    localparam logic [OP_W-1:0] OP_D  = 4'd2;
    localparam logic [OP_W-1:0] OP_N  = 4'd3;
    localparam logic [OP_W-1:0] OP_S  = 4'd4;
    localparam logic [OP_W-1:0] OP_H  = 4'd5;
    localparam logic [OP_W-1:0] OP_P  = 4'd6;
    localparam logic [OP_W-1:0] OP_EQ = 4'd7;
    localparam logic [OP_W-1:0] OP_X  = 4'd8;

    // Result rule codes
    localparam logic [RULE_W-1:0] RULE_ALIGNED  = 3'd0;
    localparam logic [RULE_W-1:0] RULE_INSERT   = 3'd1;
    localparam logic [RULE_W-1:0] RULE_CLIP     = 3'd2;
    localparam logic [RULE_W-1:0] RULE_ANCHOR   = 3'd3;
    localparam logic [RULE_W-1:0] RULE_OVERFLOW = 3'd4;

    // Which result the datapath loads into the output register
    typedef enum logic [2:0] {
        RES_ALIGNED,
        RES_INS_FALLBACK,
        RES_INS_FOUND,
        RES_CLIP_FALLBACK,
        RES_CLIP_FOUND,
        RES_ANCHOR,
        RES_OVERFLOW
    } res_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     load;       // store an input word
        logic     init;       // start the walk
        logic     rd_issue;   // read store at current index
        logic     advance;    // step pointers over the current op
        logic     keep_dist;  // note distance into a soft clip
        logic     res_load;   // load output register, empty the store
        res_sel_t res_sel;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic overflow;
        logic any_aligned;
        logic at_end;
        logic take_right;
        logic is_aligned;
        logic is_ins;
        logic is_clip;
        logic in_op;          // read offset falls within the current op
    } dp_sts_t;

    function automatic logic op_is_aligned(input logic [OP_W-1:0] c);
        return (c == OP_M) || (c == OP_EQ) || (c == OP_X);
    endfunction

endpackage

[src/cigar_read_to_ref_position.sv]
// CIGAR read offset to reference position mapper.
// Input channel (s_*): one CIGAR operation per word. The word with
// s_last_op high also carries the anchor position, the read offset and the
// insertion direction, and starts the lookup once it is stored.
// Output channel (m_*): one word per record, the mapped reference position
// and the rule that produced it. Words that are not last give no output.
// Loading takes one operation per cycle while s_ready is high. The lookup
// then walks the stored operations, each by a store read and then a step,
// through the single read port of the operation store, plus one look-ahead
// walk over the following operations for an offset inside an insertion or
// soft clip. An overflowed or unaligned record gets its result in the
// decide step, without a walk of the stored operations.
// Results sit in an output register: while it waits for m_ready, words of
// the next record are still taken, but a next last word is held off until
// the result has gone.
// Reset (aresetn low, synchronous) empties the store and drops any pending
// result. Store entries need no clearing.
module cigar_read_to_ref_position
    import crrp_pkg::*;
#(
    parameter int MAX_OPS = MAX_OPS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OP_W-1:0]       s_cigar_op,
    input  logic [LEN_W-1:0]      s_op_length,
    input  logic [ANCHOR_W-1:0]   s_anchor_pos,
    input  logic [OFF_W-1:0]      s_query_offset,
    input  logic                  s_take_right,
    input  logic                  s_last_op,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [POS_O_W-1:0]    m_mapped_ref_pos,
    output logic [RULE_W-1:0]     m_rule_used
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    crrp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_last_op (s_last_op),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    crrp_dp #(
        .MAX_OPS (MAX_OPS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_cigar_op       (s_cigar_op),
        .s_op_length      (s_op_length),
        .s_anchor_pos     (s_anchor_pos),
        .s_query_offset   (s_query_offset),
        .s_take_right     (s_take_right),
        .s_last_op        (s_last_op),
        .cmd              (cmd),
        .sts              (sts),
        .m_mapped_ref_pos (m_mapped_ref_pos),
        .m_rule_used      (m_rule_used)
    );

endmodule

[src/crrp_dp.sv]
module crrp_dp
    import crrp_pkg::*;
#(
    parameter int MAX_OPS = MAX_OPS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [OP_W-1:0]       s_cigar_op,
    input  logic [LEN_W-1:0]      s_op_length,
    input  logic [ANCHOR_W-1:0]   s_anchor_pos,
    input  logic [OFF_W-1:0]      s_query_offset,
    input  logic                  s_take_right,
    input  logic                  s_last_op,
    input  dp_cmd_t               cmd,
    output dp_sts_t               sts,
    output logic [POS_O_W-1:0]    m_mapped_ref_pos,
    output logic [RULE_W-1:0]     m_rule_used
);

    localparam int CNT_W  = $clog2(MAX_OPS + 1);
    localparam int ADDR_W = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
    // read pointer holds the sum of all lengths
    localparam int RD_W   = CNT_W + LEN_W;
    localparam int CMP_W  = ((RD_W > OFF_W) ? RD_W : OFF_W) + 1;
    // reference pointer: anchor plus all lengths, at least output width
    localparam int POS_W  = ((RD_W + 3) > POS_O_W) ? (RD_W + 3) : POS_O_W;

    logic [ENTRY_W-1:0]  mem [MAX_OPS];
    logic [ENTRY_W-1:0]  rdata_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                overflow_reg;
    logic                any_reg;
    logic [ANCHOR_W-1:0] anchor_reg;
    logic [OFF_W-1:0]    off_reg;
    logic                right_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [POS_W-1:0]    ref_reg;
    logic [RD_W-1:0]     rd_reg;
    logic [POS_W-1:0]    last_ref_reg;
    logic                has_last_reg;
    logic [LEN_W-1:0]    dist_reg;
    logic [POS_O_W-1:0]  pos_out_reg;
    logic [RULE_W-1:0]   rule_out_reg;

    logic [OP_W-1:0]     cur_op;
    logic [LEN_W-1:0]    cur_len;
    logic [CMP_W-1:0]    len_ext;
    logic [CMP_W-1:0]    rd_ext;
    logic [CMP_W-1:0]    off_ext;
    logic [CMP_W-1:0]    into_op;
    logic [CMP_W-1:0]    ahead_dist;
    logic [POS_W-1:0]    fallback;
    logic [POS_W-1:0]    clip_best;
    logic [POS_W-1:0]    res_pos;
    logic [RULE_W-1:0]   res_rule;
    logic                store_full;

    assign cur_op   = rdata_reg[ENTRY_W-1:LEN_W];
    assign cur_len  = rdata_reg[LEN_W-1:0];
    assign len_ext  = CMP_W'(cur_len);
    assign rd_ext   = CMP_W'(rd_reg);
    assign off_ext  = CMP_W'(off_reg);
    assign into_op  = off_ext - rd_ext;
    assign ahead_dist = rd_ext - off_ext;
    assign store_full = (count_reg >= CNT_W'(MAX_OPS));

    // status to the controller
    always_comb begin
        sts.overflow    = overflow_reg;
        sts.any_aligned = any_reg;
        sts.at_end      = (idx_reg == count_reg);
        sts.take_right  = right_reg;
        sts.is_aligned  = op_is_aligned(cur_op);
        sts.is_ins      = (cur_op == OP_I);
        sts.is_clip     = (cur_op == OP_S);
        sts.in_op       = (off_ext >= rd_ext) && (off_ext < rd_ext + len_ext);
    end

    // store write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.load && !store_full) begin
            mem[count_reg[ADDR_W-1:0]] <= {s_cigar_op, s_op_length};
        end
        if (cmd.rd_issue) begin
            rdata_reg <= mem[idx_reg[ADDR_W-1:0]];
        end
    end

    // record bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            any_reg      <= 1'b0;
        end else if (cmd.res_load) begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            any_reg      <= 1'b0;
        end else if (cmd.load) begin
            if (store_full) begin
                overflow_reg <= 1'b1;
            end else begin
                count_reg <= count_reg + 1'b1;
                if (op_is_aligned(s_cigar_op)) begin
                    any_reg <= 1'b1;
                end
            end
        end
    end

    // query fields arrive with the last word
    always_ff @(posedge aclk) begin
        if (cmd.load && s_last_op) begin
            anchor_reg <= s_anchor_pos;
            off_reg    <= s_query_offset;
            right_reg  <= s_take_right;
        end
    end

    // walk pointers
    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            idx_reg      <= '0;
            ref_reg      <= POS_W'(anchor_reg);
            rd_reg       <= '0;
            has_last_reg <= 1'b0;
        end else if (cmd.advance) begin
            idx_reg <= idx_reg + 1'b1;
            if (op_is_aligned(cur_op)) begin
                last_ref_reg <= ref_reg + POS_W'(cur_len) - POS_W'(1);
                has_last_reg <= 1'b1;
                ref_reg      <= ref_reg + POS_W'(cur_len);
                rd_reg       <= rd_reg + RD_W'(cur_len);
            end else if (cur_op == OP_D || cur_op == OP_N) begin
                ref_reg <= ref_reg + POS_W'(cur_len);
            end else if (cur_op == OP_I || cur_op == OP_S) begin
                rd_reg <= rd_reg + RD_W'(cur_len);
            end
        end
        if (cmd.keep_dist) begin
            dist_reg <= into_op[LEN_W-1:0];
        end
    end

    // result selection
    always_comb begin
        fallback = has_last_reg ? last_ref_reg : POS_W'(anchor_reg);
        if (!has_last_reg) begin
            clip_best = ref_reg;
        end else if (ahead_dist < CMP_W'(dist_reg) ||
                     (ahead_dist == CMP_W'(dist_reg) && ref_reg < last_ref_reg)) begin
            clip_best = ref_reg;
        end else begin
            clip_best = last_ref_reg;
        end
        case (cmd.res_sel)
            RES_ALIGNED: begin
                res_pos  = ref_reg + POS_W'(into_op);
                res_rule = RULE_ALIGNED;
            end
            RES_INS_FALLBACK: begin
                res_pos  = fallback;
                res_rule = RULE_INSERT;
            end
            RES_INS_FOUND: begin
                res_pos  = ref_reg;
                res_rule = RULE_INSERT;
            end
            RES_CLIP_FALLBACK: begin
                res_pos  = fallback;
                res_rule = RULE_CLIP;
            end
            RES_CLIP_FOUND: begin
                res_pos  = clip_best;
                res_rule = RULE_CLIP;
            end
            RES_OVERFLOW: begin
                res_pos  = POS_W'(anchor_reg);
                res_rule = RULE_OVERFLOW;
            end
            default: begin
                res_pos  = POS_W'(anchor_reg);
                res_rule = RULE_ANCHOR;
            end
        endcase
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            pos_out_reg  <= res_pos[POS_O_W-1:0];
            rule_out_reg <= res_rule;
        end
    end

    assign m_mapped_ref_pos = pos_out_reg;
    assign m_rule_used      = rule_out_reg;

endmodule

[src/crrp_ctrl.sv]
module crrp_ctrl
    import crrp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic    s_last_op,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_RD,
        ST_EXE,
        ST_LA_RD,
        ST_LA_EXE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   clip_mode_reg, clip_mode_next;

    // a new last word needs the output register free
    assign s_ready = (state_reg == ST_IDLE) && !(m_valid_reg && s_last_op);
    assign m_valid = m_valid_reg;

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        clip_mode_next = clip_mode_reg;
        cmd            = '0;
        cmd.res_sel    = RES_ANCHOR;
        case (state_reg)
            ST_IDLE: begin
                cmd.load = s_valid && s_ready;
                if (s_valid && s_ready && s_last_op) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (sts.overflow) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_OVERFLOW;
                    state_next   = ST_IDLE;
                end else if (!sts.any_aligned) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_ANCHOR;
                    state_next   = ST_IDLE;
                end else begin
                    cmd.init       = 1'b1;
                    clip_mode_next = 1'b0;
                    state_next     = ST_RD;
                end
            end
            ST_RD: begin
                if (sts.at_end) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_ANCHOR;
                    state_next   = ST_IDLE;
                end else begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ST_EXE;
                end
            end
            ST_EXE: begin
                if (sts.is_aligned && sts.in_op) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_ALIGNED;
                    state_next   = ST_IDLE;
                end else if (sts.is_ins && sts.in_op) begin
                    if (sts.take_right) begin
                        cmd.advance = 1'b1;
                        state_next  = ST_LA_RD;
                    end else begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_INS_FALLBACK;
                        state_next   = ST_IDLE;
                    end
                end else if (sts.is_clip && sts.in_op) begin
                    cmd.advance    = 1'b1;
                    cmd.keep_dist  = 1'b1;
                    clip_mode_next = 1'b1;
                    state_next     = ST_LA_RD;
                end else begin
                    cmd.advance = 1'b1;
                    state_next  = ST_RD;
                end
            end
            ST_LA_RD: begin
                if (sts.at_end) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = clip_mode_reg ? RES_CLIP_FALLBACK : RES_INS_FALLBACK;
                    state_next   = ST_IDLE;
                end else begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ST_LA_EXE;
                end
            end
            ST_LA_EXE: begin
                if (sts.is_aligned) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = clip_mode_reg ? RES_CLIP_FOUND : RES_INS_FOUND;
                    state_next   = ST_IDLE;
                end else begin
                    cmd.advance = 1'b1;
                    state_next  = ST_LA_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // output handshake
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.res_load) begin
            m_valid_next = 1'b1;
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            clip_mode_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            clip_mode_reg <= clip_mode_next;
        end
    end

endmodule
